FILE: design/ntpsod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ntpsod_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // timestamp differences of one exchange, formed by the front stage
    typedef struct packed {
        logic        start;
        logic [63:0] d41;   // T4 - T1
        logic [63:0] d32;   // T3 - T2
        logic [63:0] d21;   // T2 - T1
        logic [63:0] d34;   // T3 - T4
        logic [31:0] disp;
    } t_diff;

endpackage
`default_nettype wire

FILE: design/ntp_sample_offset_delay_core.sv
`timescale 1ns / 1ps
`default_nettype none
// NTP sample core: each transfer on the input side carries one exchange
// (T1..T4 in unsigned 32.32 plus the 16.16 root dispersion) and yields one
// result: half the round-trip delay, half the offset sum (both signed 32.32,
// arithmetic shift), the max-minus-min spread of the last up to eight delays,
// and the dispersion unchanged. start_series empties the delay window before
// the current delay is stored. A front stage forms the four timestamp
// differences and hands them through a two-entry queue to a back end that
// updates the window and scans it one entry per cycle against a running
// minimum and maximum. The back end takes an item only when idle and, after
// the scan, waits until its output register is free, so it takes no new item
// before the last is through; the front keeps taking items while the queue
// has room and a finished result waits in its output register until popped.
module ntp_sample_offset_delay_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  wire                 i_start_series,
    input  wire  [63:0]         i_client_send_time,
    input  wire  [63:0]         i_server_receive_time,
    input  wire  [63:0]         i_server_transmit_time,
    input  wire  [63:0]         i_client_receive_time,
    input  wire  [31:0]         i_root_dispersion_in,
    output logic                empty,
    input  wire                 pop,
    output logic signed [63:0]  o_half_delay,
    output logic signed [63:0]  o_clock_offset,
    output logic [63:0]         o_delay_spread,
    output logic [31:0]         o_root_dispersion_out
);

    logic              w_q_wr;
    logic              w_q_full;
    logic              w_q_rd;
    logic              w_q_empty;
    ntpsod_pkg::t_diff w_q_wr_data;
    ntpsod_pkg::t_diff w_q_rd_data;

    ntpsod_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .push                   (push),
        .full                   (full),
        .i_start_series         (i_start_series),
        .i_client_send_time     (i_client_send_time),
        .i_server_receive_time  (i_server_receive_time),
        .i_server_transmit_time (i_server_transmit_time),
        .i_client_receive_time  (i_client_receive_time),
        .i_root_dispersion_in   (i_root_dispersion_in),
        .o_q_wr                 (w_q_wr),
        .o_q_data               (w_q_wr_data),
        .i_q_full               (w_q_full)
    );

    ntpsod_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_q_wr_data),
        .o_full    (w_q_full),
        .i_rd      (w_q_rd),
        .o_rd_data (w_q_rd_data),
        .o_empty   (w_q_empty)
    );

    ntpsod_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_data              (w_q_rd_data),
        .i_q_empty             (w_q_empty),
        .o_q_rd                (w_q_rd),
        .empty                 (empty),
        .pop                   (pop),
        .o_half_delay          (o_half_delay),
        .o_clock_offset        (o_clock_offset),
        .o_delay_spread        (o_delay_spread),
        .o_root_dispersion_out (o_root_dispersion_out)
    );

endmodule
`default_nettype wire

FILE: design/ntpsod_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ntpsod_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  wire                 i_start_series,
    input  wire  [63:0]         i_client_send_time,
    input  wire  [63:0]         i_server_receive_time,
    input  wire  [63:0]         i_server_transmit_time,
    input  wire  [63:0]         i_client_receive_time,
    input  wire  [31:0]         i_root_dispersion_in,
    output logic                o_q_wr,
    output ntpsod_pkg::t_diff   o_q_data,
    input  wire                 i_q_full
);

    logic              r_valid;
    ntpsod_pkg::t_diff r_item;
    logic              w_accept;

    assign o_q_wr   = r_valid && !i_q_full;
    assign o_q_data = r_item;
    assign full     = r_valid && i_q_full;
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_wr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.start <= i_start_series;
            r_item.d41   <= i_client_receive_time - i_client_send_time;
            r_item.d32   <= i_server_transmit_time - i_server_receive_time;
            r_item.d21   <= i_server_receive_time - i_client_send_time;
            r_item.d34   <= i_server_transmit_time - i_client_receive_time;
            r_item.disp  <= i_root_dispersion_in;
        end
    end

endmodule
`default_nettype wire

FILE: design/ntpsod_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ntpsod_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr,
    input  ntpsod_pkg::t_diff   i_wr_data,
    output logic                o_full,
    input  wire                 i_rd,
    output ntpsod_pkg::t_diff   o_rd_data,
    output logic                o_empty
);

    ntpsod_pkg::t_diff                      r_mem [ntpsod_pkg::FIFO_DEPTH];
    logic [ntpsod_pkg::FIFO_PTR_W-1:0]      r_wr_ptr;
    logic [ntpsod_pkg::FIFO_PTR_W-1:0]      r_rd_ptr;
    logic [ntpsod_pkg::FIFO_CNT_W-1:0]      r_count;
    logic                                   w_wr;
    logic                                   w_rd;

    localparam logic [ntpsod_pkg::FIFO_PTR_W-1:0] PtrLast =
        ntpsod_pkg::FIFO_PTR_W'(ntpsod_pkg::FIFO_DEPTH - 1);

    assign o_full    = (r_count == ntpsod_pkg::FIFO_CNT_W'(ntpsod_pkg::FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/ntpsod_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ntpsod_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ntpsod_pkg::t_diff   i_q_data,
    input  wire                 i_q_empty,
    output logic                o_q_rd,
    output logic                empty,
    input  wire                 pop,
    output logic signed [63:0]  o_half_delay,
    output logic signed [63:0]  o_clock_offset,
    output logic [63:0]         o_delay_spread,
    output logic [31:0]         o_root_dispersion_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [ntpsod_pkg::IDX_W-1:0] IdxLast =
        ntpsod_pkg::IDX_W'(ntpsod_pkg::WINDOW_DEPTH - 1);
    localparam logic [ntpsod_pkg::CNT_W-1:0] CntFull =
        ntpsod_pkg::CNT_W'(ntpsod_pkg::WINDOW_DEPTH);

    t_state                           r_state;
    logic [63:0]                      r_window [ntpsod_pkg::WINDOW_DEPTH];
    logic [ntpsod_pkg::IDX_W-1:0]     r_slot;
    logic [ntpsod_pkg::CNT_W-1:0]     r_count;
    logic [ntpsod_pkg::IDX_W-1:0]     r_scan;
    logic [63:0]                      r_lo;
    logic [63:0]                      r_hi;
    logic [63:0]                      r_half_delay;
    logic [63:0]                      r_half_offset;
    logic [31:0]                      r_disp;
    logic                             r_out_valid;
    logic [63:0]                      r_out_half_delay;
    logic [63:0]                      r_out_offset;
    logic [63:0]                      r_out_spread;
    logic [31:0]                      r_out_disp;

    logic [63:0]                      w_delay;
    logic [63:0]                      w_offs;
    logic [ntpsod_pkg::IDX_W-1:0]     w_slot;
    logic [ntpsod_pkg::IDX_W-1:0]     n_slot;
    logic [ntpsod_pkg::CNT_W-1:0]     n_count;
    logic [63:0]                      w_entry;
    logic                             w_last;
    logic                             w_out_free;

    assign w_delay = i_q_data.d41 - i_q_data.d32;
    assign w_offs  = i_q_data.d21 + i_q_data.d34;
    assign w_slot  = i_q_data.start ? '0 : r_slot;
    assign n_slot  = (w_slot == IdxLast) ? '0 : w_slot + 1'b1;
    assign n_count = i_q_data.start ? ntpsod_pkg::CNT_W'(1)
                   : ((r_count == CntFull) ? r_count : r_count + 1'b1);
    assign w_entry = r_window[r_scan];
    assign w_last  = (ntpsod_pkg::CNT_W'(r_scan) == r_count - 1'b1);

    assign o_q_rd     = (r_state == S_IDLE) && !i_q_empty;
    assign w_out_free = !r_out_valid || pop;

    assign empty                 = !r_out_valid;
    assign o_half_delay          = $signed(r_out_half_delay);
    assign o_clock_offset        = $signed(r_out_offset);
    assign o_delay_spread        = r_out_spread;
    assign o_root_dispersion_out = r_out_disp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, else drop the one that was transferred
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_rd) begin
                        r_window[w_slot] <= w_delay;
                        r_slot           <= n_slot;
                        r_count          <= n_count;
                        r_scan           <= '0;
                        r_lo             <= w_delay;
                        r_hi             <= w_delay;
                        r_half_delay     <= {w_delay[63], w_delay[63:1]};
                        r_half_offset    <= {w_offs[63], w_offs[63:1]};
                        r_disp           <= i_q_data.disp;
                        r_state          <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one window entry per cycle, signed order
                    if ($signed(w_entry) < $signed(r_lo)) begin
                        r_lo <= w_entry;
                    end
                    if ($signed(w_entry) > $signed(r_hi)) begin
                        r_hi <= w_entry;
                    end
                    if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_half_delay <= r_half_delay;
                        r_out_offset     <= r_half_offset;
                        r_out_spread     <= r_hi - r_lo;
                        r_out_disp       <= r_disp;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntFull)
        else $error("window fill count beyond depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0) && (ntpsod_pkg::CNT_W'(r_scan) < r_count))
        else $error("scan outside filled window");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) && $past(i_rst_n) |-> $past(pop))
        else $error("result dropped without transfer");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !pop |=> (r_state == S_DONE))
        else $error("result overwritten while waiting");

endmodule
`default_nettype wire
